### rtl/fcu_pkg.sv
// Package for the frame checksum unit: mode codes, the running state type,
// and the byte-wide CRC update functions. No dependencies.

package fcu_pkg;

   // Checksum mode codes, as written to the mode register.
   typedef logic [2:0] mode_type;
   localparam mode_type MODE_CRC16_MSB  = 3'd0;
   localparam mode_type MODE_WORD_SUM   = 3'd1;
   localparam mode_type MODE_CRC16_REFL = 3'd2;
   localparam mode_type MODE_CRC32      = 3'd3;
   localparam mode_type MODE_BYTE_SUM   = 3'd4;

   // Polynomials and seeds.
   localparam logic [15:0] CRC16_MSB_POLY  = 16'h1021;
   localparam logic [31:0] CRC16_REFL_POLY = 32'h0000_A001;
   localparam logic [31:0] CRC32_POLY      = 32'hEDB8_8320;
   localparam logic [31:0] CRC32_SEED      = 32'hFFFF_FFFF;

   // Running state carried from one byte of a frame to the next.
   typedef struct packed {
      logic [31:0] running_value;
      logic [7:0]  held_high_byte;
      logic        byte_waiting;
   } sum_state_type;

   // State at the start of a frame for the given mode.
   function automatic sum_state_type seed_state(input mode_type mode);
      sum_state_type s;
      s.running_value  = (mode == MODE_CRC32) ? CRC32_SEED : 32'd0;
      s.held_high_byte = 8'd0;
      s.byte_waiting   = 1'b0;
      return s;
   endfunction

   // MSB-first CRC-16, one byte unrolled over eight bit steps.
   function automatic logic [15:0] crc16_msb_byte(input logic [15:0] crc,
                                                  input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'd0};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC16_MSB_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Reflected CRC, one byte unrolled over eight bit steps.
   function automatic logic [31:0] crc_refl_byte(input logic [31:0] crc,
                                                 input logic [7:0]  data,
                                                 input logic [31:0] poly);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = {1'b0, c[31:1]} ^ poly;
         end else begin
            c = {1'b0, c[31:1]};
         end
      end
      return c;
   endfunction

endpackage

### rtl/fcu_step.sv
// Single-byte update of the frame checksum: next running state and the
// finished checksum for the selected mode. Depends on fcu_pkg.

module fcu_step
   import fcu_pkg::*;
(
   input  mode_type      mode,
   input  sum_state_type cur_state,
   input  logic [7:0]    frame_byte,
   input  logic          is_last,
   output sum_state_type nxt_state,
   output logic [31:0]   checksum_value
);

   sum_state_type upd_state;
   logic [15:0]   crc16_msb;
   logic [31:0]   crc_refl16;
   logic [31:0]   crc_refl32;
   logic [31:0]   word_sum;
   logic [16:0]   fold_once;
   logic [16:0]   fold_twice;

   // All three CRC flavors are computed in parallel; the mode picks one below.
   assign crc16_msb  = crc16_msb_byte(cur_state.running_value[15:0], frame_byte);
   assign crc_refl16 = crc_refl_byte({16'd0, cur_state.running_value[15:0]},
                                     frame_byte, CRC16_REFL_POLY);
   assign crc_refl32 = crc_refl_byte(cur_state.running_value, frame_byte, CRC32_POLY);

   // Word sum: pair bytes big-endian; a lone trailing byte is added unshifted.
   always_comb begin
      if (cur_state.byte_waiting) begin
         word_sum = cur_state.running_value + {16'd0, cur_state.held_high_byte, frame_byte};
      end else if (is_last) begin
         word_sum = cur_state.running_value + {24'd0, frame_byte};
      end else begin
         word_sum = cur_state.running_value;
      end
   end

   // Fold the 32-bit sum to 16 bits twice, then invert.
   assign fold_once  = {1'b0, word_sum[31:16]} + {1'b0, word_sum[15:0]};
   assign fold_twice = fold_once + {16'd0, fold_once[16]};

   // Per-mode state update and result.
   always_comb begin
      upd_state      = cur_state;
      checksum_value = 32'd0;
      case (mode)
         MODE_CRC16_MSB: begin
            upd_state.running_value = {16'd0, crc16_msb};
            checksum_value          = {16'd0, crc16_msb};
         end
         MODE_WORD_SUM: begin
            upd_state.running_value = word_sum;
            if (!cur_state.byte_waiting && !is_last) begin
               upd_state.held_high_byte = frame_byte;
               upd_state.byte_waiting   = 1'b1;
            end else begin
               upd_state.byte_waiting = 1'b0;
            end
            checksum_value = {16'd0, ~fold_twice[15:0]};
         end
         MODE_CRC16_REFL: begin
            upd_state.running_value = crc_refl16;
            checksum_value          = crc_refl16;
         end
         MODE_CRC32: begin
            upd_state.running_value = crc_refl32;
            checksum_value          = crc_refl32 ^ CRC32_SEED;
         end
         MODE_BYTE_SUM: begin
            upd_state.running_value = cur_state.running_value + {24'd0, frame_byte};
            checksum_value          = upd_state.running_value;
         end
         default: begin
            checksum_value = 32'd0;
         end
      endcase
   end

   // The last byte of a frame reseeds for the next frame.
   assign nxt_state = is_last ? seed_state(mode) : upd_state;

endmodule

### rtl/frame_checksum_unit.sv
// Top level of the frame checksum unit: input register, checksum update and
// result register. Depends on fcu_pkg and fcu_step.
//
// Usage:
//   Input channel req_*: one frame byte per transaction, with req_is_last set
//   on the final byte. Frames are one byte or longer.
//   Result channel rsp_*: one transaction per frame, carrying the checksum
//   of the frame; 16-bit modes return zero in the upper half.
//   Configuration: csr_write_enable with csr_write_data selects the mode and
//   reseeds the running state. Write it only while no frame is in flight.
// Flow:
//   An accepted byte is held in the input register and updated there by
//   fcu_step; the checksum of a final byte is then registered in the result
//   register and shown on rsp_*. One byte is taken per cycle, except while a
//   final byte is held behind a pending result.
// Stalls:
//   While a result waits on rsp_ready, non-final bytes keep flowing; a final
//   byte waits in the input register, and req_ready drops behind it.
// Reset:
//   Synchronous reset empties both registers, selects mode 0 (MSB-first
//   CRC-16) and seeds the running state to zero.

module frame_checksum_unit
   import fcu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_checksum_value,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data
);

   mode_type      mode_ff, mode_in;
   sum_state_type state_ff, state_in;
   sum_state_type step_state;
   logic [31:0]   step_value;
   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_byte_ff, s1_byte_in;
   logic          s1_last_ff, s1_last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic          req_fire;
   logic          s1_fire;

   // The input register moves on unless it holds a final byte and the
   // result register is still occupied.
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // Checksum update for the byte in the input register.
   fcu_step u_step (
      .mode           (mode_ff),
      .cur_state      (state_ff),
      .frame_byte     (s1_byte_ff),
      .is_last        (s1_last_ff),
      .nxt_state      (step_state),
      .checksum_value (step_value)
   );

   // Next-state logic for control, running state and result.
   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s1_byte_in   = req_fire ? req_frame_byte : s1_byte_ff;
      s1_last_in   = req_fire ? req_is_last : s1_last_ff;
      mode_in      = csr_write_enable ? mode_type'(csr_write_data) : mode_ff;
      if (csr_write_enable) begin
         state_in = seed_state(mode_type'(csr_write_data));
      end else if (s1_fire) begin
         state_in = step_state;
      end else begin
         state_in = state_ff;
      end
      rsp_valid_in = (s1_fire && s1_last_ff) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_value_in = (s1_fire && s1_last_ff) ? step_value : rsp_value_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_CRC16_MSB;
         state_ff     <= seed_state(MODE_CRC16_MSB);
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_byte_ff   <= s1_byte_in;
      s1_last_ff   <= s1_last_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_checksum_value = rsp_value_ff;

`ifndef SYNTHESIS
   // A half word is only ever held in word-sum mode.
   a_wait_only_word_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff.byte_waiting |-> (mode_ff == MODE_WORD_SUM))
      else $error("held byte outside word-sum mode");

   // The 16-bit CRC modes keep the upper half of the running value clear.
   a_crc16_upper_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_CRC16_MSB || mode_ff == MODE_CRC16_REFL)
         |-> (state_ff.running_value[31:16] == 16'd0))
      else $error("16-bit CRC running value overflowed");

   // A final byte blocked by a pending result stays in the input register.
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready)
         |=> (s1_valid_ff && s1_last_ff))
      else $error("final byte lost while result stalled");

   // Reset leaves both stages empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule
